FILE: sv/scs_pkg.sv
// types and constants for the striped circle span generator
// standalone package, no dependencies
`default_nettype none

package scs_pkg;

    localparam int IN_COORD_W  = 12;
    localparam int RADIUS_W    = 7;
    localparam int ROW_W       = 8;
    localparam int OUT_W       = 13;
    localparam int SQ_W        = 15;
    localparam int SQRT_STEPS  = 7;
    // highest even bit position of a 14-bit radicand
    localparam int SQRT_TOP    = 12;

    typedef struct packed {
        logic [IN_COORD_W-1:0] x0;
        logic [IN_COORD_W-1:0] y0;
        logic [RADIUS_W-1:0]   r;
        logic [ROW_W-1:0]      row;
        logic                  last;
    } span_item_t;

endpackage

`default_nettype wire

FILE: sv/striped_circle_span_generator.sv
// striped circle span generator: row walker, squares, pipelined integer sqrt
// depends on scs_pkg
`default_nettype none

// throughput: one span per cycle while out_ready is high; a circle of radius r
// (saturated) yields r spans and the next circle is taken once the row walker
// has issued the last row
// the sqrt is a seven-stage restoring pipeline, one result bit per stage
// reset clears the row walker and all valid bits; payload registers are not reset
module striped_circle_span_generator #(
    parameter int MAX_RADIUS = 64,
    parameter int COORD_BITS = 12
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [scs_pkg::IN_COORD_W-1:0] origin_x,
    input  wire  [scs_pkg::IN_COORD_W-1:0] origin_y,
    input  wire  [scs_pkg::RADIUS_W-1:0]   circle_radius,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [scs_pkg::OUT_W-1:0]      span_x_start,
    output logic [scs_pkg::OUT_W-1:0]      span_x_end,
    output logic [scs_pkg::OUT_W-1:0]      span_y,
    output logic                           last_span
);

    localparam int CW       = scs_pkg::IN_COORD_W;
    localparam int RW       = scs_pkg::RADIUS_W;
    localparam int OW       = scs_pkg::OUT_W;
    localparam int QW       = scs_pkg::SQ_W;
    localparam int STEPS    = scs_pkg::SQRT_STEPS;
    localparam int KEEP     = (COORD_BITS < CW) ? COORD_BITS : CW;
    localparam logic [CW:0] MaskWide = (CW + 1)'((1 << KEEP) - 1);
    localparam logic [CW-1:0] CoordMask = MaskWide[CW-1:0];
    localparam logic [RW-1:0] RadMax = RW'(MAX_RADIUS);

    logic advance;
    assign advance = !out_valid || out_ready;

    // row walker
    logic                        active_reg;
    logic [CW-1:0]               held_x_reg;
    logic [CW-1:0]               held_y_reg;
    logic [RW-1:0]               held_r_reg;
    logic [scs_pkg::ROW_W-1:0]   row_reg;
    logic [scs_pkg::ROW_W:0]     row_plus2;
    logic [scs_pkg::ROW_W:0]     two_r;
    logic                        walk_last;
    logic                        issue;
    logic [RW-1:0]               r_eff;

    assign in_ready  = !active_reg;
    assign r_eff     = (circle_radius > RadMax) ? RadMax : circle_radius;
    assign row_plus2 = {1'b0, row_reg} + 9'd2;
    assign two_r     = {1'b0, held_r_reg, 1'b0};
    assign walk_last = row_plus2 >= two_r;
    assign issue     = active_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            held_x_reg <= '0;
            held_y_reg <= '0;
            held_r_reg <= '0;
            row_reg    <= '0;
        end
        else if (in_valid && in_ready)
        begin
            held_x_reg <= origin_x & CoordMask;
            held_y_reg <= origin_y & CoordMask;
            held_r_reg <= r_eff;
            row_reg    <= 8'd1;
            active_reg <= (r_eff != '0);
        end
        else if (issue)
        begin
            if (walk_last)
            begin
                active_reg <= 1'b0;
                row_reg    <= '0;
            end
            else
            begin
                row_reg <= row_plus2[scs_pkg::ROW_W-1:0];
            end
        end
    end

    // stage a: distance from the center row
    scs_pkg::span_item_t a_item_reg;
    logic                a_valid_reg;
    logic [RW-1:0]       a_habs_reg;
    logic [scs_pkg::ROW_W-1:0] r_wide;
    logic [scs_pkg::ROW_W-1:0] habs_next;

    assign r_wide    = {1'b0, held_r_reg};
    assign habs_next = (row_reg > r_wide) ? (row_reg - r_wide) : (r_wide - row_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_item_reg.x0   <= held_x_reg;
            a_item_reg.y0   <= held_y_reg;
            a_item_reg.r    <= held_r_reg;
            a_item_reg.row  <= row_reg;
            a_item_reg.last <= walk_last;
            a_habs_reg      <= habs_next[RW-1:0];
        end
    end

    // stage b: squares
    scs_pkg::span_item_t b_item_reg;
    logic                b_valid_reg;
    logic [2*RW-1:0]     b_rr_reg;
    logic [2*RW-1:0]     b_hh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (advance)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_item_reg <= a_item_reg;
            b_rr_reg   <= a_item_reg.r * a_item_reg.r;
            b_hh_reg   <= a_habs_reg * a_habs_reg;
        end
    end

    // sqrt pipeline, entry 0 holds the radicand
    scs_pkg::span_item_t sq_item_reg  [0:STEPS];
    logic                sq_valid_reg [0:STEPS];
    logic [QW-1:0]       sq_rem_reg   [0:STEPS];
    logic [QW-1:0]       sq_res_reg   [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (advance)
            sq_valid_reg[0] <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_item_reg[0] <= b_item_reg;
            sq_rem_reg[0]  <= QW'(b_rr_reg - b_hh_reg);
            sq_res_reg[0]  <= '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_sqrt
        localparam logic [QW-1:0] Bit = QW'(1) << (scs_pkg::SQRT_TOP - 2 * k);
        logic [QW-1:0] trial;
        logic [QW-1:0] rem_next;
        logic [QW-1:0] res_next;

        assign trial = sq_res_reg[k] + Bit;

        always_comb
        begin
            if (sq_rem_reg[k] >= trial)
            begin
                rem_next = sq_rem_reg[k] - trial;
                res_next = (sq_res_reg[k] >> 1) + Bit;
            end
            else
            begin
                rem_next = sq_rem_reg[k];
                res_next = sq_res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[k+1] <= 1'b0;
            else if (advance)
                sq_valid_reg[k+1] <= sq_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                sq_item_reg[k+1] <= sq_item_reg[k];
                sq_rem_reg[k+1]  <= rem_next;
                sq_res_reg[k+1]  <= res_next;
            end
        end
    end

    // output word
    scs_pkg::span_item_t fin;
    logic [OW:0]         center;
    logic [OW:0]         half;
    logic [OW:0]         xs_next;
    logic [OW:0]         xe_next;
    logic [OW:0]         y_next;

    assign fin     = sq_item_reg[STEPS];
    assign center  = (OW + 1)'(fin.x0) + (OW + 1)'(fin.r);
    assign half    = (OW + 1)'(sq_res_reg[STEPS][RW-1:0]);
    assign xs_next = center - half;
    assign xe_next = center + half - 14'd1;
    assign y_next  = (OW + 1)'(fin.y0) + (OW + 1)'(fin.row);

    logic out_valid_reg;
    logic [OW-1:0] xs_reg;
    logic [OW-1:0] xe_reg;
    logic [OW-1:0] y_reg;
    logic          last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= sq_valid_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xs_reg   <= xs_next[OW-1:0];
            xe_reg   <= xe_next[OW-1:0];
            y_reg    <= y_next[OW-1:0];
            last_reg <= fin.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign span_x_start = xs_reg;
    assign span_x_end   = xe_reg;
    assign span_y       = y_reg;
    assign last_span    = last_reg;

endmodule

`default_nettype wire

FILE: sim/tb_striped_circle_span_generator.sv
// testbench for striped_circle_span_generator: drives circles, predicts every span
// word and checks the output stream in order; depends on scs_pkg and the block rtl
module tb_striped_circle_span_generator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_W        = scs_pkg::OUT_W;
    localparam int IN_COORD_W   = scs_pkg::IN_COORD_W;
    localparam int RADIUS_W     = scs_pkg::RADIUS_W;
    localparam int SAT_RADIUS   = 64;
    localparam int COORD_BITS   = 12;
    localparam int RANDOM_COUNT = 430;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 400;

    typedef struct {
        bit [OUT_W-1:0] x_start;
        bit [OUT_W-1:0] x_end;
        bit [OUT_W-1:0] y;
        bit             last;
    } span_t;

    // fixed_spans: -1 means use the predictor, 0 or 1 means typed-in spans
    typedef struct {
        bit [IN_COORD_W-1:0] x;
        bit [IN_COORD_W-1:0] y;
        bit [RADIUS_W-1:0]   r;
        int                  fixed_spans;
        span_t               span;
    } circle_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [IN_COORD_W-1:0] origin_x = '0;
    logic [IN_COORD_W-1:0] origin_y = '0;
    logic [RADIUS_W-1:0]   circle_radius = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OUT_W-1:0]      span_x_start;
    logic [OUT_W-1:0]      span_x_end;
    logic [OUT_W-1:0]      span_y;
    logic                  last_span;

    span_t       pending_spans[$];
    circle_row_t circle_table[];
    int          fails = 0;
    int          spans_checked = 0;
    int          circles_sent = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    bit          calm = 1'b0;

    striped_circle_span_generator #(
        .MAX_RADIUS(SAT_RADIUS),
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .origin_x(origin_x),
        .origin_y(origin_y),
        .circle_radius(circle_radius),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .span_x_start(span_x_start),
        .span_x_end(span_x_end),
        .span_y(span_y),
        .last_span(last_span)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int unsigned floor_root(int unsigned v);
        int unsigned a;
        a = 0;
        while ((a + 1) * (a + 1) <= v)
            a++;
        return a;
    endfunction

    // one span word per odd row, radius saturated to the block's maximum
    function automatic void predict_circle_spans(bit [IN_COORD_W-1:0] x,
                                                 bit [IN_COORD_W-1:0] y,
                                                 bit [RADIUS_W-1:0] r_in);
        int unsigned r;
        int unsigned h;
        int unsigned a;
        span_t       s;
        r = (r_in > SAT_RADIUS) ? SAT_RADIUS : r_in;
        for (int unsigned i = 1; i < 2 * r; i += 2)
        begin
            h = (i > r) ? i - r : r - i;
            a = floor_root(r * r - h * h);
            s.x_start = OUT_W'(x + r - a);
            s.x_end   = OUT_W'(x + r + a - 1);
            s.y       = OUT_W'(y + i);
            s.last    = (i + 2 >= 2 * r);
            pending_spans.insert(pending_spans.size(), s);
        end
    endfunction

    task automatic send_circle(circle_row_t row);
        while (!calm && $urandom_range(99) < 6)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        origin_x      <= row.x;
        origin_y      <= row.y;
        circle_radius <= row.r;
        do
            @(posedge clk);
        while (!in_ready);
        if (row.fixed_spans < 0)
            predict_circle_spans(row.x, row.y, row.r);
        else if (row.fixed_spans == 1)
            pending_spans.insert(pending_spans.size(), row.span);
        circles_sent++;
    endtask

    // stop offering and wait until every span word has come back
    task automatic drain_spans();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_spans.size() != 0)
            @(posedge clk);
    endtask

    function automatic circle_row_t make_row(int x, int y, int r, int fixed_spans,
                                             int xs, int xe, int sy);
        circle_row_t row;
        row.x           = IN_COORD_W'(x);
        row.y           = IN_COORD_W'(y);
        row.r           = RADIUS_W'(r);
        row.fixed_spans = fixed_spans;
        row.span        = '{x_start: OUT_W'(xs), x_end: OUT_W'(xe), y: OUT_W'(sy),
                            last: 1'b1};
        return row;
    endfunction

    function automatic circle_row_t random_row();
        int unsigned pick;
        int unsigned r;
        pick = $urandom_range(99);
        if (pick < 60)
            r = $urandom_range(8, 1);
        else if (pick < 80)
            r = ($urandom_range(3) == 0) ? 0 : $urandom_range(31, 9);
        else if (pick < 95)
            r = $urandom_range(64, 32);
        else
            r = $urandom_range(127, 65);
        return make_row($urandom_range(4095), $urandom_range(4095), r, -1, 0, 0, 0);
    endfunction

    // receiver: random stalls plus one long hold-off once traffic is flowing
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
        else if (!hold_done && spans_checked >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        out_ready <= rst_n && (hold_left == 0) && (calm || $urandom_range(99) >= 6);
    end

    always @(posedge clk)
    begin
        span_t exp_span;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_spans.size() == 0)
            begin
                $error("span word with nothing expected: x %0d..%0d y %0d",
                       span_x_start, span_x_end, span_y);
                fails++;
            end
            else
            begin
                exp_span = pending_spans.pop_front();
                if (span_x_start !== exp_span.x_start)
                begin
                    $error("span_x_start expected %0d got %0d", exp_span.x_start, span_x_start);
                    fails++;
                end
                if (span_x_end !== exp_span.x_end)
                begin
                    $error("span_x_end expected %0d got %0d", exp_span.x_end, span_x_end);
                    fails++;
                end
                if (span_y !== exp_span.y)
                begin
                    $error("span_y expected %0d got %0d", exp_span.y, span_y);
                    fails++;
                end
                if (last_span !== exp_span.last)
                begin
                    $error("last_span expected %0d got %0d", exp_span.last, last_span);
                    fails++;
                end
            end
            spans_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d span words still due",
                     cycle_count, pending_spans.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        circle_table = '{
            make_row(0,    0,    0,   0, 0,    0,    0),
            make_row(4095, 4095, 0,   0, 0,    0,    0),
            make_row(0,    0,    1,   1, 0,    1,    1),
            make_row(4095, 4095, 1,   1, 4095, 4096, 4096),
            make_row(0,    4095, 1,   1, 0,    1,    4096),
            make_row(4095, 0,    1,   1, 4095, 4096, 1),
            make_row(100,  200,  2,  -1, 0,    0,    0),
            make_row(0,    0,    64, -1, 0,    0,    0),
            make_row(4095, 4095, 64, -1, 0,    0,    0),
            make_row(1234, 3210, 65, -1, 0,    0,    0),
            make_row(4095, 4095, 127, -1, 0,   0,    0),
            make_row(2730, 1365, 3,  -1, 0,    0,    0),
            make_row(1365, 2730, 85, -1, 0,    0,    0),
            make_row(7,    9,    42, -1, 0,    0,    0),
            make_row(0,    0,    0,   0, 0,    0,    0),
            make_row(4095, 0,    1,   1, 4095, 4096, 1),
            make_row(17,   33,   5,  -1, 0,    0,    0),
            make_row(4000, 4000, 63, -1, 0,    0,    0)
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (circle_table[k])
            send_circle(circle_table[k]);
        drain_spans();

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            calm = (n >= 150 && n < 250);
            if (n == 300)
                drain_spans();
            send_circle(random_row());
        end
        calm = 1'b0;
        drain_spans();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d circles sent, %0d span words checked, radii from zero to saturation",
                 circles_sent, spans_checked);
        $display("origins at both coordinate extremes, long output stall and input drain covered");
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
sv/scs_pkg.sv
sv/striped_circle_span_generator.sv
sim/tb_striped_circle_span_generator.sv
